[rtl/xsed_pkg.sv]
package xsed_pkg;

  localparam int MAX_STREAMS = 1024;
  localparam int TBL_AW      = $clog2(MAX_STREAMS);
  localparam int CNT_W       = $clog2(MAX_STREAMS + 1);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [7:0] TYPE_FREE       = 8'h00;
  localparam logic [7:0] TYPE_IN_USE     = 8'h01;
  localparam logic [7:0] TYPE_COMPRESSED = 8'h02;

  localparam logic [1:0] CFG_TYPE_BYTES  = 2'd0;
  localparam logic [1:0] CFG_LOC_BYTES   = 2'd1;
  localparam logic [1:0] CFG_THIRD_BYTES = 2'd2;

  typedef enum logic [1:0] {
    SC_OK       = 2'd0,
    SC_BAD_TYPE = 2'd1,
    SC_FULL     = 2'd2,
    SC_TRUNC    = 2'd3
  } xsed_status_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SEARCH,
    BS_DONE
  } xsed_bstate_t;

  typedef struct packed {
    logic [7:0]   entry_type;
    logic [31:0]  obj_num;
    logic [31:0]  location;
    logic [31:0]  generation_or_index;
    logic         is_free;
    logic         is_objstm;
    xsed_status_t status;
    logic         clr_tbl;
    logic         report;
  } xsed_item_t;

  typedef struct packed {
    logic valid;
    logic err;
  } xsed_resp_t;

endpackage

[rtl/xsed_ram.sv]
module xsed_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/xsed_queue.sv]
module xsed_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  xsed_pkg::xsed_item_t din,
  output logic               full,
  input  logic               pop,
  output xsed_pkg::xsed_item_t dout,
  output logic               empty
);
  import xsed_pkg::*;

  xsed_item_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[rtl/xsed_front.sv]
module xsed_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_starts_stream,
  input  logic                 in_starts_subsection,
  input  logic [31:0]          in_first_object_number,
  input  logic                 in_last_byte,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [2:0]           cfg_data,
  output logic                 q_push,
  output xsed_pkg::xsed_item_t q_item,
  input  logic                 q_full,
  input  xsed_pkg::xsed_resp_t resp
);
  import xsed_pkg::*;

  logic [2:0]       tb_cfg_r, lb_cfg_r, gb_cfg_r;
  logic [3:0]       pos_r, pos_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [31:0]      loc_r, loc_nxt;
  logic [31:0]      third_r, third_nxt;
  logic [31:0]      sub_r, sub_nxt;
  logic [31:0]      eis_r, eis_nxt;
  logic             err_r, err_nxt;
  logic             wait_r, wait_nxt;
  logic             clr_r, clr_nxt;
  logic [CNT_W-1:0] ccnt_r, ccnt_nxt;

  logic [2:0]       tb, lb, gb;
  logic [3:0]       tl, total;
  logic             accept, restart;
  logic [3:0]       pos_e, pos_n;
  logic [7:0]       type_e, type_n;
  logic [31:0]      loc_e, loc_n, third_e, third_n, sub_e, eis_e, objn;
  logic             err_e, clr_e, done;
  logic [CNT_W-1:0] ccnt_e;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_cfg_r <= 3'd1;
      lb_cfg_r <= 3'd2;
      gb_cfg_r <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TYPE_BYTES:  tb_cfg_r <= cfg_data;
        CFG_LOC_BYTES:   lb_cfg_r <= cfg_data;
        CFG_THIRD_BYTES: gb_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // field widths saturated into their legal ranges
  assign tb    = (tb_cfg_r == 3'd0) ? 3'd1 : (tb_cfg_r > 3'd4) ? 3'd4 : tb_cfg_r;
  assign lb    = (lb_cfg_r == 3'd0) ? 3'd1 : (lb_cfg_r > 3'd4) ? 3'd4 : lb_cfg_r;
  assign gb    = (gb_cfg_r > 3'd4) ? 3'd4 : gb_cfg_r;
  assign tl    = {1'b0, tb} + {1'b0, lb};
  assign total = tl + {1'b0, gb};

  assign in_full = wait_r || q_full;
  assign accept  = in_push && !in_full;
  assign restart = in_starts_stream || in_starts_subsection;

  assign pos_e   = restart ? 4'd0 : pos_r;
  assign type_e  = restart ? 8'd0 : type_r;
  assign loc_e   = restart ? 32'd0 : loc_r;
  assign third_e = restart ? 32'd0 : third_r;
  assign sub_e   = in_starts_subsection ? in_first_object_number : sub_r;
  assign eis_e   = in_starts_subsection ? 32'd0 : eis_r;
  assign err_e   = in_starts_stream ? 1'b0 : err_r;
  assign ccnt_e  = in_starts_stream ? '0 : ccnt_r;
  assign clr_e   = clr_r || in_starts_stream;

  // byte steering by position
  assign type_n  = (pos_e < {1'b0, tb}) ? in_data_byte : type_e;
  assign loc_n   = (pos_e >= {1'b0, tb} && pos_e < tl) ? {loc_e[23:0], in_data_byte} : loc_e;
  assign third_n = (pos_e >= tl) ? {third_e[23:0], in_data_byte} : third_e;
  assign pos_n   = pos_e + 4'd1;
  assign done    = (pos_n >= total);
  assign objn    = sub_e + eis_e;

  always_comb begin
    pos_nxt   = pos_r;
    type_nxt  = type_r;
    loc_nxt   = loc_r;
    third_nxt = third_r;
    sub_nxt   = sub_r;
    eis_nxt   = eis_r;
    err_nxt   = err_r;
    wait_nxt  = wait_r;
    clr_nxt   = clr_r;
    ccnt_nxt  = ccnt_r;
    q_push    = 1'b0;
    q_item    = '0;
    if (wait_r && resp.valid) begin
      wait_nxt = 1'b0;
      err_nxt  = resp.err;
    end
    if (accept) begin
      pos_nxt   = pos_e;
      type_nxt  = type_e;
      loc_nxt   = loc_e;
      third_nxt = third_e;
      sub_nxt   = sub_e;
      eis_nxt   = eis_e;
      err_nxt   = err_e;
      ccnt_nxt  = ccnt_e;
      clr_nxt   = clr_e;
      if (!err_e) begin
        pos_nxt   = pos_n;
        type_nxt  = type_n;
        loc_nxt   = loc_n;
        third_nxt = third_n;
        if (done || in_last_byte) begin
          q_push         = 1'b1;
          q_item.clr_tbl = clr_e;
          clr_nxt        = 1'b0;
          pos_nxt        = 4'd0;
          type_nxt       = 8'd0;
          loc_nxt        = 32'd0;
          third_nxt      = 32'd0;
          if (!done) begin
            q_item.status = SC_TRUNC;
            err_nxt       = 1'b1;
          end else begin
            eis_nxt           = eis_e + 32'd1;
            q_item.entry_type = type_n;
            case (type_n)
              TYPE_FREE: begin
                q_item.obj_num             = loc_n;
                q_item.generation_or_index = (gb == 3'd0) ? 32'd0 : third_n;
                q_item.is_free             = 1'b1;
              end
              TYPE_IN_USE: begin
                q_item.obj_num             = objn;
                q_item.location            = loc_n;
                q_item.generation_or_index = (gb == 3'd0) ? 32'd0 : third_n;
              end
              TYPE_COMPRESSED: begin
                q_item.obj_num             = objn;
                q_item.location            = loc_n;
                q_item.generation_or_index = (gb == 3'd0) ? 32'd0 : third_n;
                q_item.is_objstm           = 1'b1;
                // table may be full: hold input until the back end answers
                if (ccnt_e >= CNT_W'(MAX_STREAMS)) begin
                  q_item.report = 1'b1;
                  wait_nxt      = 1'b1;
                end else begin
                  ccnt_nxt = ccnt_e + 1'b1;
                end
              end
              default: begin
                q_item.status = SC_BAD_TYPE;
                err_nxt       = 1'b1;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      type_r  <= '0;
      loc_r   <= '0;
      third_r <= '0;
      sub_r   <= '0;
      eis_r   <= '0;
      err_r   <= 1'b0;
      wait_r  <= 1'b0;
      clr_r   <= 1'b0;
      ccnt_r  <= '0;
    end else begin
      pos_r   <= pos_nxt;
      type_r  <= type_nxt;
      loc_r   <= loc_nxt;
      third_r <= third_nxt;
      sub_r   <= sub_nxt;
      eis_r   <= eis_nxt;
      err_r   <= err_nxt;
      wait_r  <= wait_nxt;
      clr_r   <= clr_nxt;
      ccnt_r  <= ccnt_nxt;
    end
  end

endmodule

[rtl/xsed_back.sv]
module xsed_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  xsed_pkg::xsed_item_t q_item,
  input  logic                 q_empty,
  output logic                 q_pop,
  output xsed_pkg::xsed_resp_t resp,
  output logic                 res_valid,
  output xsed_pkg::xsed_item_t res_item,
  output logic                 res_new,
  input  logic                 res_pop
);
  import xsed_pkg::*;

  xsed_bstate_t     state_r, state_nxt;
  xsed_item_t       cur_r, cur_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic             found_r, found_nxt;
  logic             ov_r, ov_nxt;
  xsed_item_t       ores_r, ores_nxt;
  logic             onew_r, onew_nxt;

  logic [CNT_W-1:0] cnt_e;
  logic             out_free, issue, hit, is_new, needs_search;
  logic             ram_we;
  logic [31:0]      ram_rdata;

  xsed_ram #(.WIDTH(32), .DEPTH(MAX_STREAMS)) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[TBL_AW-1:0]),
    .wdata (cur_r.location),
    .raddr (rd_idx_r[TBL_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign res_valid    = ov_r;
  assign res_item     = ores_r;
  assign res_new      = onew_r;
  assign out_free     = !ov_r || res_pop;
  assign cnt_e        = q_item.clr_tbl ? '0 : count_r;
  assign needs_search = q_item.is_objstm && (cnt_e < CNT_W'(MAX_STREAMS))
                        && (cnt_e != '0);
  assign issue        = (rd_idx_r < count_r);
  assign hit          = cmp_v_r && (ram_rdata == cur_r.location);
  assign is_new       = cur_r.is_objstm && (cur_r.status == SC_OK) && !found_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          state_nxt = needs_search ? BS_SEARCH : BS_DONE;
        end
      end
      BS_SEARCH: begin
        if (hit || (!issue && !cmp_v_r)) begin
          state_nxt = BS_DONE;
        end
      end
      BS_DONE: begin
        if (out_free) begin
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    cur_nxt    = cur_r;
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    cmp_v_nxt  = 1'b0;
    found_nxt  = found_r;
    ores_nxt   = ores_r;
    onew_nxt   = onew_r;
    ov_nxt     = (ov_r && res_pop) ? 1'b0 : ov_r;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    resp       = '0;
    case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          cur_nxt    = q_item;
          count_nxt  = cnt_e;
          rd_idx_nxt = '0;
          found_nxt  = 1'b0;
          if (q_item.is_objstm && cnt_e >= CNT_W'(MAX_STREAMS)) begin
            cur_nxt.status = SC_FULL;
          end
        end
      end
      BS_SEARCH: begin
        rd_idx_nxt = issue ? rd_idx_r + 1'b1 : rd_idx_r;
        cmp_v_nxt  = issue && !hit;
        found_nxt  = found_r || hit;
      end
      BS_DONE: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          ores_nxt   = cur_r;
          onew_nxt   = is_new;
          ram_we     = is_new;
          count_nxt  = is_new ? count_r + 1'b1 : count_r;
          resp.valid = cur_r.report;
          resp.err   = (cur_r.status == SC_FULL);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BS_IDLE;
      count_r  <= '0;
      rd_idx_r <= '0;
      cmp_v_r  <= 1'b0;
      found_r  <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_idx_r <= rd_idx_nxt;
      cmp_v_r  <= cmp_v_nxt;
      found_r  <= found_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    ores_r <= ores_nxt;
    onew_r <= onew_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_STREAMS))
    else $error("stream count above table size");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (count_r < CNT_W'(MAX_STREAMS)))
    else $error("table write with no room");

  a_search_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_SEARCH) |-> (cur_r.is_objstm && cur_r.status == SC_OK
                                && rd_idx_r <= count_r))
    else $error("search on an item that needs none");

  a_resp_item: assert property (@(posedge clk) disable iff (!rst_n)
    resp.valid |-> (cur_r.is_objstm && ov_nxt))
    else $error("answer to front end without a compressed item");

endmodule

[rtl/xref_stream_entry_decoder_core.sv]
// Cross-reference stream entry decoder.
// Input channel: one stream byte per item with its framing flags, pushed with
// in_push while in_full is low. starts_stream and starts_subsection act on the
// byte they come with. Result channel: one decoded entry per completed entry
// (or one truncation result), shown while out_empty is low and taken with
// out_pop. Config channel: cfg_index selects the width register, always ready;
// write it only while the block is idle.
// The front end takes one byte per cycle while in_full is low and queues
// finished entries (4 deep) for the back end. A compressed entry searches the
// stream table, when it is neither empty nor full, one entry per cycle through
// its RAM read port, stopping early on a match. A result passes through the
// queue, the back end's item register and its output register.
// Once as many compressed entries as the table holds have come since the
// stream start, each further one stalls input until its table check finishes.
// Reset clears all control state; table contents need no clearing.
// A stalled result receiver fills the output register, then the queue, and
// then raises in_full.
module xref_stream_entry_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_starts_stream,
  input  logic        in_starts_subsection,
  input  logic [31:0] in_first_object_number,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_entry_type,
  output logic [31:0] out_obj_num,
  output logic [31:0] out_location,
  output logic [31:0] out_generation_or_index,
  output logic        out_is_free,
  output logic        out_is_objstm,
  output logic        out_new_object_stream,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);
  import xsed_pkg::*;

  xsed_item_t fq_item, qb_item, res_item;
  xsed_resp_t resp;
  logic       fq_push, q_full, q_empty, q_pop, res_valid, res_new;

  xsed_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_data_byte           (in_data_byte),
    .in_starts_stream       (in_starts_stream),
    .in_starts_subsection   (in_starts_subsection),
    .in_first_object_number (in_first_object_number),
    .in_last_byte           (in_last_byte),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .q_push                 (fq_push),
    .q_item                 (fq_item),
    .q_full                 (q_full),
    .resp                   (resp)
  );

  xsed_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   (fq_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (qb_item),
    .empty (q_empty)
  );

  xsed_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (qb_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .resp      (resp),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_new   (res_new),
    .res_pop   (out_pop)
  );

  assign out_empty               = !res_valid;
  assign out_entry_type          = res_item.entry_type;
  assign out_obj_num             = res_item.obj_num;
  assign out_location            = res_item.location;
  assign out_generation_or_index = res_item.generation_or_index;
  assign out_is_free             = res_item.is_free;
  assign out_is_objstm           = res_item.is_objstm;
  assign out_new_object_stream   = res_new;
  assign out_status              = res_item.status;

endmodule
